FILE: rtl/core/pa_gain_cal_bilinear_lookup_top_assert.svh
// Assertion macros shared by the PA gain calibration lookup RTL.
// Expects signals named aclk and aresetn in the including module.
`ifndef PA_GAIN_CAL_BILINEAR_LOOKUP_TOP_ASSERT_SVH
`define PA_GAIN_CAL_BILINEAR_LOOKUP_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PGCBL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define PGCBL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`else
`define PGCBL_ASSERT(label, prop, msg)
`define PGCBL_ASSERT_IMP(label, ante, cons, msg)
`endif
`endif

FILE: rtl/core/pgcbl_pkg.sv
// Shared types and constants for the PA gain calibration lookup.
// No dependencies.
`timescale 1ns / 1ps
package pgcbl_pkg;
    localparam int MAX_POINTS_DEF = 16;
    localparam int MAX_BANDS_DEF  = 32;
    localparam int FREQ_W  = 24;
    localparam int VAL_W   = 16;
    localparam int NVAL    = 5;
    localparam int Q_W     = 16;
    localparam int S_W     = 128;
    localparam int M_W     = 88;

    localparam logic [1:0] OP_APPEND_POINT = 2'd0;
    localparam logic [1:0] OP_APPEND_BAND  = 2'd1;
    localparam logic [1:0] OP_LOOKUP       = 2'd2;
    localparam logic [1:0] OP_RESERVED     = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Value slots of a band: radio temp, PA temp, attenuator, low power, high power.
    localparam int IDX_RADIO = 0;
    localparam int IDX_PAM   = 1;
    localparam int IDX_VVA   = 2;
    localparam int IDX_LOW   = 3;
    localparam int IDX_HIGH  = 4;

    typedef logic [NVAL-1:0][VAL_W-1:0] band_t;

    typedef struct packed {
        logic accept;
        logic append;
        logic set_miss;
        logic set_ok;
        logic pt_clear;
        logic pt_next;
        logic pick_single;
        logic pick_pair;
        logic band_start;
        logic band_step;
        logic sel_eval;
        logic div_pw;
        logic lerp_pw;
        logic eval_next;
        logic eval_last;
        logic div_fr;
        logic lerp_fr;
        logic out_load;
    } pgcbl_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic pc_zero;
        logic pt_eq;
        logic pt_br;
        logic pt_last;
        logic n_zero;
        logic low_hit;
        logic band_last;
        logic ev_fail;
        logic ev_lerp;
        logic div_done;
        logic lerp_done;
        logic pair;
        logic phase;
        logic out_free;
    } pgcbl_stat_t;
endpackage

FILE: rtl/core/pgcbl_div.sv
// Restoring divider giving an unsigned Q16 ratio num/den with num < den.
// Depends on pgcbl_pkg.
`timescale 1ns / 1ps
module pgcbl_div
    import pgcbl_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [FREQ_W-1:0] num,
    input  logic [FREQ_W-1:0] den,
    output logic              done,
    output logic [Q_W-1:0]    q
);
    localparam int CNT_W = $clog2(Q_W + 1);

    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [FREQ_W:0]   rem_reg;
    logic [FREQ_W-1:0] den_reg;
    logic [Q_W-1:0]    q_reg;
    logic [FREQ_W+1:0] shifted;
    logic [FREQ_W+1:0] trial;
    logic              ge;

    assign shifted = {rem_reg, 1'b0};
    assign trial   = shifted - {2'b00, den_reg};
    assign ge      = shifted >= {2'b00, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(Q_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? trial[FREQ_W:0] : shifted[FREQ_W:0];
            q_reg   <= {q_reg[Q_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign q    = q_reg;
endmodule

FILE: rtl/core/pgcbl_dp.sv
// Datapath of the calibration lookup: table memories, scan registers,
// interpolation multiplier and output register. Depends on pgcbl_pkg, pgcbl_div.
`timescale 1ns / 1ps
module pgcbl_dp
    import pgcbl_pkg::*;
#(
    parameter int MP = MAX_POINTS_DEF,
    parameter int MB = MAX_BANDS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  pgcbl_cmd_t     cmd,
    output pgcbl_stat_t    stat,
    input  logic [S_W-1:0] s_tdata,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [M_W-1:0] m_tdata
);
    localparam int PI_W = $clog2(MP);
    localparam int PC_W = $clog2(MP + 1);
    localparam int BI_W = $clog2(MB);
    localparam int BC_W = $clog2(MB + 1);
    localparam int BA_W = $clog2(MP * MB);

    function automatic logic signed [VAL_W:0] ext_val(input int k, input logic [VAL_W-1:0] v);
        ext_val = (k == IDX_VVA) ? $signed({1'b0, v}) : $signed({v[VAL_W-1], v});
    endfunction

    // Storage
    logic [FREQ_W-1:0] freq_mem [MP];
    logic [BC_W-1:0]   bc_mem   [MP];
    band_t             band_mem [MP*MB];
    logic [FREQ_W-1:0] freq_rd_reg;
    logic [BC_W-1:0]   bc_rd_reg;
    band_t             band_rd_reg;

    // Item registers
    logic [1:0]              op_reg;
    logic [FREQ_W-1:0]       f_reg;
    logic signed [VAL_W-1:0] pw_reg;
    band_t                   load_reg;

    // Control state
    logic [PC_W-1:0] pc_reg;
    logic [BC_W-1:0] last_bc_reg;
    logic [1:0]      status_reg;
    logic            val_ok_reg;
    logic [PI_W-1:0] pt_idx_reg;
    logic [PI_W-1:0] p_reg;
    logic            pair_reg;
    logic            phase_reg;
    logic [BI_W-1:0] j_reg;
    logic [BC_W-1:0] n_reg;
    logic            eql_reg;
    logic            eqh_reg;
    logic            br_reg;
    logic            out_valid_reg;
    logic            lerp_act_reg;
    logic            lerp_fr_reg;
    logic [2:0]      lk_reg;
    logic            pvalid_reg;
    logic [2:0]      pk_reg;

    // Payload registers
    logic [FREQ_W-1:0] prev_freq_reg;
    logic [FREQ_W-1:0] fnum_reg;
    logic [FREQ_W-1:0] fden_reg;
    band_t             eql_vals_reg;
    band_t             eqh_vals_reg;
    band_t             br_a_reg;
    band_t             br_b_reg;
    logic [VAL_W-1:0]  br_num_reg;
    logic [VAL_W-1:0]  br_den_reg;
    band_t             first_reg;
    band_t             prev_reg;
    band_t             r_reg;
    band_t             va_reg;
    band_t             vb_reg;
    logic [Q_W:0]      ratio_reg;
    logic signed [2*VAL_W+3:0] prod_reg;
    logic [M_W-1:0]    out_data_reg;

    // Write side
    logic [PI_W-1:0] last_p;
    logic [BA_W-1:0] wr_addr;
    logic [BA_W-1:0] rd_addr;
    logic            pt_full;
    logic            bd_ok;

    assign last_p  = PI_W'(pc_reg - 1'b1);
    assign wr_addr = BA_W'(last_p) * BA_W'(MB) + BA_W'(last_bc_reg);
    assign rd_addr = BA_W'(p_reg) * BA_W'(MB) + BA_W'(j_reg);
    assign pt_full = (pc_reg == PC_W'(MP));
    assign bd_ok   = (pc_reg != '0) && (last_bc_reg != BC_W'(MB));

    always_ff @(posedge aclk) begin
        if (cmd.append && op_reg == OP_APPEND_POINT && !pt_full) begin
            freq_mem[pc_reg[PI_W-1:0]] <= f_reg;
        end
        if (cmd.append && op_reg == OP_APPEND_POINT && !pt_full) begin
            bc_mem[pc_reg[PI_W-1:0]] <= '0;
        end else if (cmd.append && op_reg == OP_APPEND_BAND && bd_ok) begin
            bc_mem[last_p] <= last_bc_reg + 1'b1;
        end
        if (cmd.append && op_reg == OP_APPEND_BAND && bd_ok) begin
            band_mem[wr_addr] <= load_reg;
        end
        freq_rd_reg <= freq_mem[pt_idx_reg];
        bc_rd_reg   <= bc_mem[p_reg];
        band_rd_reg <= band_mem[rd_addr];
    end

    // Band scan compares
    logic signed [VAL_W-1:0] cur_lo, cur_hi, prv_lo, prv_hi;
    logic low_hit, high_hit, br_lo, br_hi;
    assign cur_lo   = $signed(band_rd_reg[IDX_LOW]);
    assign cur_hi   = $signed(band_rd_reg[IDX_HIGH]);
    assign prv_lo   = $signed(prev_reg[IDX_LOW]);
    assign prv_hi   = $signed(prev_reg[IDX_HIGH]);
    assign low_hit  = (cur_lo == pw_reg);
    assign high_hit = (cur_hi == pw_reg);
    assign br_lo    = (j_reg != '0) && (pw_reg < prv_lo) && (pw_reg > cur_lo);
    assign br_hi    = (j_reg != '0) && (pw_reg < prv_hi) && (pw_reg > cur_hi);

    logic above_first, below_last, eq_any;
    assign above_first = pw_reg > $signed(first_reg[IDX_HIGH]);
    assign below_last  = (pw_reg < prv_hi) || (pw_reg < prv_lo);
    assign eq_any      = eql_reg || eqh_reg;

    // Divider
    logic              div_start, div_done;
    logic [FREQ_W-1:0] div_num, div_den;
    logic [Q_W-1:0]    div_q;
    assign div_start = cmd.div_pw || cmd.div_fr;
    assign div_num   = cmd.div_fr ? fnum_reg : FREQ_W'(br_num_reg);
    assign div_den   = cmd.div_fr ? fden_reg : FREQ_W'(br_den_reg);

    pgcbl_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .q       (div_q)
    );

    // Interpolation: one product per cycle, then lo + trunc(product / 2^16).
    band_t lo_src, hi_src;
    logic signed [VAL_W+1:0]   diff;
    logic signed [VAL_W:0]     lo_pk;
    logic signed [2*VAL_W+3:0] tq;
    logic [VAL_W+1:0]          sum;
    assign lo_src = lerp_fr_reg ? va_reg : br_a_reg;
    assign hi_src = lerp_fr_reg ? vb_reg : br_b_reg;
    assign diff   = (VAL_W+2)'(ext_val(int'(lk_reg), hi_src[lk_reg]))
                  - (VAL_W+2)'(ext_val(int'(lk_reg), lo_src[lk_reg]));
    assign lo_pk  = ext_val(int'(pk_reg), lo_src[pk_reg]);
    assign tq     = prod_reg[2*VAL_W+3] ? ((prod_reg + (2*VAL_W+4)'(65535)) >>> Q_W)
                                        : (prod_reg >>> Q_W);
    assign sum    = (VAL_W+2)'(lo_pk) + tq[VAL_W+1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg        <= '0;
            last_bc_reg   <= '0;
            status_reg    <= ST_MISS;
            val_ok_reg    <= 1'b0;
            pt_idx_reg    <= '0;
            p_reg         <= '0;
            pair_reg      <= 1'b0;
            phase_reg     <= 1'b0;
            j_reg         <= '0;
            n_reg         <= '0;
            eql_reg       <= 1'b0;
            eqh_reg       <= 1'b0;
            br_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            lerp_act_reg  <= 1'b0;
            lerp_fr_reg   <= 1'b0;
            lk_reg        <= '0;
            pvalid_reg    <= 1'b0;
            pk_reg        <= '0;
        end else begin
            if (cmd.accept) begin
                val_ok_reg <= 1'b0;
            end
            if (cmd.append) begin
                if (op_reg == OP_APPEND_POINT) begin
                    if (pt_full) begin
                        status_reg <= ST_FULL;
                    end else begin
                        pc_reg      <= pc_reg + 1'b1;
                        last_bc_reg <= '0;
                        status_reg  <= ST_OK;
                    end
                end else if (pc_reg == '0) begin
                    status_reg <= ST_MISS;
                end else if (!bd_ok) begin
                    status_reg <= ST_FULL;
                end else begin
                    last_bc_reg <= last_bc_reg + 1'b1;
                    status_reg  <= ST_OK;
                end
            end
            if (cmd.set_miss) begin
                status_reg <= ST_MISS;
            end
            if (cmd.set_ok) begin
                status_reg <= ST_OK;
                val_ok_reg <= 1'b1;
            end
            if (cmd.pt_clear) begin
                pt_idx_reg <= '0;
            end
            if (cmd.pt_next) begin
                pt_idx_reg <= pt_idx_reg + 1'b1;
            end
            if (cmd.pick_single) begin
                p_reg    <= pt_idx_reg;
                pair_reg <= 1'b0;
            end
            if (cmd.pick_pair) begin
                p_reg     <= pt_idx_reg - 1'b1;
                pair_reg  <= 1'b1;
                phase_reg <= 1'b0;
            end
            if (cmd.eval_next) begin
                p_reg     <= p_reg + 1'b1;
                phase_reg <= 1'b1;
            end
            if (cmd.band_start) begin
                n_reg   <= bc_rd_reg;
                j_reg   <= '0;
                eql_reg <= 1'b0;
                eqh_reg <= 1'b0;
                br_reg  <= 1'b0;
            end
            if (cmd.band_step) begin
                j_reg <= j_reg + 1'b1;
                if (low_hit) begin
                    eql_reg <= 1'b1;
                end
                if (high_hit) begin
                    eqh_reg <= 1'b1;
                end
                if (br_lo || br_hi) begin
                    br_reg <= 1'b1;
                end
            end
            if (cmd.lerp_pw || cmd.lerp_fr) begin
                lerp_act_reg <= 1'b1;
                lerp_fr_reg  <= cmd.lerp_fr;
                lk_reg       <= '0;
            end else if (lerp_act_reg) begin
                lk_reg <= lk_reg + 1'b1;
                if (lk_reg == 3'(NVAL - 1)) begin
                    lerp_act_reg <= 1'b0;
                end
            end
            pvalid_reg <= lerp_act_reg;
            pk_reg     <= lk_reg;
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg   <= s_tdata[1:0];
            f_reg    <= s_tdata[25:2];
            pw_reg   <= $signed(s_tdata[41:26]);
            load_reg <= s_tdata[121:42];
        end
        if (cmd.pt_next) begin
            prev_freq_reg <= freq_rd_reg;
        end
        if (cmd.pick_pair) begin
            fnum_reg <= f_reg - prev_freq_reg;
            fden_reg <= freq_rd_reg - prev_freq_reg;
        end
        if (cmd.band_step) begin
            prev_reg <= band_rd_reg;
            if (j_reg == '0) begin
                first_reg <= band_rd_reg;
            end
            if (low_hit && !eql_reg) begin
                eql_vals_reg <= band_rd_reg;
            end
            if (high_hit && !eqh_reg) begin
                eqh_vals_reg <= band_rd_reg;
            end
            if ((br_lo || br_hi) && !br_reg) begin
                br_a_reg <= prev_reg;
                br_b_reg <= band_rd_reg;
                if (br_lo) begin
                    br_num_reg <= VAL_W'(prv_lo - pw_reg);
                    br_den_reg <= VAL_W'(prv_lo - cur_lo);
                end else begin
                    br_num_reg <= VAL_W'(prv_hi - pw_reg);
                    br_den_reg <= VAL_W'(prv_hi - cur_hi);
                end
            end
        end
        if (cmd.sel_eval) begin
            if (eql_reg) begin
                r_reg <= eql_vals_reg;
            end else if (eqh_reg) begin
                r_reg <= eqh_vals_reg;
            end else if (!br_reg && above_first) begin
                r_reg <= first_reg;
            end else if (!br_reg) begin
                r_reg <= prev_reg;
            end
        end
        if (cmd.eval_next) begin
            va_reg <= r_reg;
        end
        if (cmd.eval_last) begin
            vb_reg <= r_reg;
        end
        if (cmd.lerp_pw || cmd.lerp_fr) begin
            ratio_reg <= {1'b0, div_q};
        end
        if (lerp_act_reg) begin
            prod_reg <= (2*VAL_W+4)'(diff) * (2*VAL_W+4)'($signed({1'b0, ratio_reg}));
        end
        if (pvalid_reg) begin
            r_reg[pk_reg] <= sum[VAL_W-1:0];
        end
        if (cmd.out_load) begin
            out_data_reg <= {6'b0, (val_ok_reg ? r_reg : band_t'(0)), status_reg};
        end
    end

    assign stat.op        = op_reg;
    assign stat.pc_zero   = (pc_reg == '0);
    assign stat.pt_eq     = (freq_rd_reg == f_reg);
    assign stat.pt_br     = (pt_idx_reg != '0) && (f_reg > prev_freq_reg)
                          && (f_reg < freq_rd_reg);
    assign stat.pt_last   = (pt_idx_reg == last_p);
    assign stat.n_zero    = (bc_rd_reg == '0);
    assign stat.low_hit   = low_hit;
    assign stat.band_last = (BC_W'(j_reg) + 1'b1 == n_reg);
    assign stat.ev_lerp   = !eq_any && br_reg;
    assign stat.ev_fail   = !eq_any && !br_reg && !above_first && !below_last;
    assign stat.div_done  = div_done;
    assign stat.lerp_done = pvalid_reg && (pk_reg == 3'(NVAL - 1));
    assign stat.pair      = pair_reg;
    assign stat.phase     = phase_reg;
    assign stat.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
endmodule

FILE: rtl/core/pgcbl_ctrl.sv
// Controller state machine of the calibration lookup; sequences the datapath.
// Depends on pgcbl_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "pa_gain_cal_bilinear_lookup_top_assert.svh"
module pgcbl_ctrl
    import pgcbl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output pgcbl_cmd_t  cmd,
    input  pgcbl_stat_t stat
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_OP     = 4'd1;
    localparam logic [3:0] S_P_RD   = 4'd2;
    localparam logic [3:0] S_P_CHK  = 4'd3;
    localparam logic [3:0] S_BC_RD  = 4'd4;
    localparam logic [3:0] S_BC_CHK = 4'd5;
    localparam logic [3:0] S_B_RD   = 4'd6;
    localparam logic [3:0] S_B_CHK  = 4'd7;
    localparam logic [3:0] S_SEL    = 4'd8;
    localparam logic [3:0] S_BDIV   = 4'd9;
    localparam logic [3:0] S_BLERP  = 4'd10;
    localparam logic [3:0] S_EVDONE = 4'd11;
    localparam logic [3:0] S_FDIV   = 4'd12;
    localparam logic [3:0] S_FLERP  = 4'd13;
    localparam logic [3:0] S_DONE   = 4'd14;

    logic [3:0] state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = S_OP;
                end
            end
            S_OP: begin
                case (stat.op)
                    OP_APPEND_POINT, OP_APPEND_BAND: begin
                        cmd.append = 1'b1;
                        state_next = S_DONE;
                    end
                    OP_LOOKUP: begin
                        if (stat.pc_zero) begin
                            cmd.set_miss = 1'b1;
                            state_next   = S_DONE;
                        end else begin
                            cmd.pt_clear = 1'b1;
                            state_next   = S_P_RD;
                        end
                    end
                    default: begin
                        cmd.set_miss = 1'b1;
                        state_next   = S_DONE;
                    end
                endcase
            end
            S_P_RD: state_next = S_P_CHK;
            S_P_CHK: begin
                if (stat.pt_eq) begin
                    cmd.pick_single = 1'b1;
                    state_next      = S_BC_RD;
                end else if (stat.pt_br) begin
                    cmd.pick_pair = 1'b1;
                    state_next    = S_BC_RD;
                end else if (stat.pt_last) begin
                    cmd.set_miss = 1'b1;
                    state_next   = S_DONE;
                end else begin
                    cmd.pt_next = 1'b1;
                    state_next  = S_P_RD;
                end
            end
            S_BC_RD: state_next = S_BC_CHK;
            S_BC_CHK: begin
                if (stat.n_zero) begin
                    cmd.set_miss = 1'b1;
                    state_next   = S_DONE;
                end else begin
                    cmd.band_start = 1'b1;
                    state_next     = S_B_RD;
                end
            end
            S_B_RD: state_next = S_B_CHK;
            S_B_CHK: begin
                cmd.band_step = 1'b1;
                state_next = (stat.low_hit || stat.band_last) ? S_SEL : S_B_RD;
            end
            S_SEL: begin
                cmd.sel_eval = 1'b1;
                if (stat.ev_fail) begin
                    cmd.set_miss = 1'b1;
                    state_next   = S_DONE;
                end else if (stat.ev_lerp) begin
                    cmd.div_pw = 1'b1;
                    state_next = S_BDIV;
                end else begin
                    state_next = S_EVDONE;
                end
            end
            S_BDIV: begin
                if (stat.div_done) begin
                    cmd.lerp_pw = 1'b1;
                    state_next  = S_BLERP;
                end
            end
            S_BLERP: begin
                if (stat.lerp_done) begin
                    state_next = S_EVDONE;
                end
            end
            S_EVDONE: begin
                if (!stat.pair) begin
                    cmd.set_ok = 1'b1;
                    state_next = S_DONE;
                end else if (!stat.phase) begin
                    cmd.eval_next = 1'b1;
                    state_next    = S_BC_RD;
                end else begin
                    cmd.eval_last = 1'b1;
                    cmd.div_fr    = 1'b1;
                    state_next    = S_FDIV;
                end
            end
            S_FDIV: begin
                if (stat.div_done) begin
                    cmd.lerp_fr = 1'b1;
                    state_next  = S_FLERP;
                end
            end
            S_FLERP: begin
                if (stat.lerp_done) begin
                    cmd.set_ok = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `PGCBL_ASSERT_IMP(a_accept_to_op, s_tvalid && s_tready, ##1 state_reg == S_OP, "no decode")
    `PGCBL_ASSERT_IMP(a_div_done_wait, stat.div_done, state_reg == S_BDIV || state_reg == S_FDIV, "div")
    `PGCBL_ASSERT_IMP(a_lerp_done_wait, stat.lerp_done, state_reg == S_BLERP || state_reg == S_FLERP, "lerp")
    `PGCBL_ASSERT(a_band_chk_order, (state_reg == S_B_CHK) |-> ($past(state_reg) == S_B_RD), "band")
endmodule

FILE: rtl/core/pa_gain_cal_bilinear_lookup_top.sv
// Top level of the PA gain calibration table with bilinear lookup.
// Depends on pgcbl_pkg, pgcbl_ctrl, pgcbl_dp (which holds pgcbl_div).
//
//  Channel  Direction  Signals                   Carries
//  s_       in         s_tvalid/s_tready/s_tdata  operation, frequency, power, band load data
//  m_       out        m_tvalid/m_tready/m_tdata  status and five interpolated values
//
// Each item is handled on its own. A lookup scans the points, then for each evaluated
// point scans its bands, with a division and an interpolation when a band pair is used,
// and for a bracketing point pair a further division and interpolation; the band
// memory has a registered read port and the divider is bit-serial. Reset (aresetn low,
// synchronous) empties the table; no clearing pass is needed. A stalled result sits in
// the output register and the next transfer is taken meanwhile; it finishes once that
// register is free.
`timescale 1ns / 1ps
module pa_gain_cal_bilinear_lookup_top
    import pgcbl_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int MAX_BANDS  = MAX_BANDS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    // operation[1:0], frequency[25:2], power[41:26], load_radio_temp[57:42],
    // load_pam_temp[73:58], load_vva[89:74], load_low_power[105:90],
    // load_high_power[121:106], zero fill above
    input  logic [S_W-1:0] s_tdata,
    output logic           m_tvalid,
    input  logic           m_tready,
    // status[1:0], radio_temp[17:2], pam_temp[33:18], vva_setting[49:34],
    // low_gain_power[65:50], high_gain_power[81:66], zero fill above
    output logic [M_W-1:0] m_tdata
);
    // Command and status bundles between the sequencer and the datapath.
    pgcbl_cmd_t  cmd;
    pgcbl_stat_t stat;

    pgcbl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    pgcbl_dp #(
        .MP (MAX_POINTS),
        .MB (MAX_BANDS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );
endmodule
